// ===== rtl/length_prefixed_message_deframer_defines.svh =====
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer_defines
// assertion macros used by the deframer top module
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_MESSAGE_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_MESSAGE_DEFRAMER_DEFINES_SVH

// same-cycle implication, masked while reset is held
`define LPMD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// next-cycle implication, checked through reset as well
`define LPMD_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

// ===== rtl/lpmd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpmd_pkg
// types and constants shared by the deframer front, queue and back
// ----------------------------------------------------------------------------
package lpmd_pkg;

    localparam int HDR_LEN_BYTES = 4;
    localparam int HDR_CNT_W     = 3;
    localparam int LEN_W         = 32;
    localparam int BYTE_W        = 8;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_EMPTY   = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] opcode;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] data;
        logic              first;
        logic              last;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic can_push;
        logic not_empty;
    } t_qstat;

endpackage

// ===== rtl/lpmd_front.sv =====
// ----------------------------------------------------------------------------
// lpmd_front
// takes raw bytes, tracks header and payload position, classifies each byte
// ----------------------------------------------------------------------------
module lpmd_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [7:0]             i_data,
    input  lpmd_pkg::t_qstat       i_qstat,
    output logic                   o_ready,
    output lpmd_pkg::t_push        o_push
);
    import lpmd_pkg::*;

    typedef enum logic {
        PH_HEADER  = 1'b0,
        PH_PAYLOAD = 1'b1
    } t_phase;

    t_phase                r_phase,    n_phase;
    logic [HDR_CNT_W-1:0]  r_hdr_cnt,  n_hdr_cnt;
    logic [LEN_W-1:0]      r_length,   n_length;
    logic [BYTE_W-1:0]     r_opcode,   n_opcode;
    logic [LEN_W-1:0]      r_remain,   n_remain;
    logic                  r_first,    n_first;
    logic                  w_accept;
    logic                  w_last;

    assign o_ready  = i_qstat.can_push;
    assign w_accept = i_valid && i_qstat.can_push;
    assign w_last   = (r_remain <= LEN_W'(1));

    always_comb begin
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_length  = r_length;
        n_opcode  = r_opcode;
        n_remain  = r_remain;
        n_first   = r_first;
        o_push    = '0;
        if (w_accept) begin
            case (r_phase)
                PH_PAYLOAD: begin
                    o_push.valid        = 1'b1;
                    o_push.entry.kind   = KIND_PAYLOAD;
                    o_push.entry.opcode = r_opcode;
                    o_push.entry.length = r_length;
                    o_push.entry.data   = i_data;
                    o_push.entry.first  = r_first;
                    o_push.entry.last   = w_last;
                    n_first = 1'b0;
                    if (r_remain != '0) begin
                        n_remain = r_remain - LEN_W'(1);
                    end
                    if (w_last) begin
                        n_phase   = PH_HEADER;
                        n_hdr_cnt = '0;
                        n_remain  = '0;
                        n_first   = 1'b1;
                    end
                end
                default: begin
                    if (r_hdr_cnt < HDR_CNT_W'(HDR_LEN_BYTES)) begin
                        // big-endian length, shift in low
                        n_length  = {r_length[LEN_W-BYTE_W-1:0], i_data};
                        n_hdr_cnt = r_hdr_cnt + HDR_CNT_W'(1);
                    end else begin
                        n_opcode  = i_data;
                        n_hdr_cnt = '0;
                        n_first   = 1'b1;
                        if (r_length == '0) begin
                            // empty message marker
                            o_push.valid        = 1'b1;
                            o_push.entry.kind   = KIND_EMPTY;
                            o_push.entry.opcode = i_data;
                            o_push.entry.length = r_length;
                            o_push.entry.data   = '0;
                            o_push.entry.first  = 1'b1;
                            o_push.entry.last   = 1'b1;
                            n_phase = PH_HEADER;
                        end else begin
                            n_remain = r_length;
                            n_phase  = PH_PAYLOAD;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_hdr_cnt <= '0;
            r_length  <= '0;
            r_opcode  <= '0;
            r_remain  <= '0;
            r_first   <= 1'b1;
        end else begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_length  <= n_length;
            r_opcode  <= n_opcode;
            r_remain  <= n_remain;
            r_first   <= n_first;
        end
    end

endmodule

// ===== rtl/lpmd_queue.sv =====
// ----------------------------------------------------------------------------
// lpmd_queue
// short fifo of classified results between front and back
// ----------------------------------------------------------------------------
module lpmd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lpmd_pkg::t_push    i_push,
    input  logic               i_pop,
    output lpmd_pkg::t_qstat   o_stat,
    output lpmd_pkg::t_entry   o_head
);
    import lpmd_pkg::*;

    t_entry                r_slots [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0]   r_count,  n_count;
    logic                  w_push;
    logic                  w_pop;

    assign o_stat.can_push  = (r_count != QUEUE_CW'(QUEUE_DEPTH));
    assign o_stat.not_empty = (r_count != '0);
    assign o_head           = r_slots[r_rd_ptr];

    assign w_push = i_push.valid && o_stat.can_push;
    assign w_pop  = i_pop && o_stat.not_empty;

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + QUEUE_AW'(1) : r_wr_ptr;
        n_rd_ptr = w_pop  ? r_rd_ptr + QUEUE_AW'(1) : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + QUEUE_CW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slots[r_wr_ptr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== rtl/lpmd_back.sv =====
// ----------------------------------------------------------------------------
// lpmd_back
// drains the queue into the registered output stream
// ----------------------------------------------------------------------------
module lpmd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lpmd_pkg::t_entry   i_head,
    input  lpmd_pkg::t_qstat   i_qstat,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [47:0]        o_data,
    output logic [1:0]         o_user,
    output logic               o_last
);
    import lpmd_pkg::*;

    logic               r_valid;
    logic [47:0]        r_data,  n_data;
    logic [1:0]         r_user,  n_user;
    logic               r_last;
    logic               w_has_payload;

    // load whenever the output slot is free or being taken
    assign o_pop   = i_qstat.not_empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_user  = r_user;
    assign o_last  = r_last;

    always_comb begin
        case (i_head.kind)
            KIND_PAYLOAD: w_has_payload = 1'b1;
            KIND_EMPTY:   w_has_payload = 1'b0;
            default:      w_has_payload = 1'b0;
        endcase
        n_data = {(w_has_payload ? i_head.data : 8'h00), i_head.length, i_head.opcode};
        n_user = {i_head.first, w_has_payload};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= n_data;
            r_user <= n_user;
            r_last <= i_head.last;
        end
    end

endmodule

// ===== rtl/length_prefixed_message_deframer.sv =====
// a taken byte's result goes into the result queue, then into the output register
// throughput: one byte per cycle, sustained; the front stalls only when the
// 4-entry result queue is full because the output side is holding back
// header bytes and the opcode of a non-empty message are consumed and give no result
// reset (synchronous, active low) returns to expecting a length header, empties the queue
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer
// splits a byte stream of length/opcode/payload messages into payload and marker results
// ----------------------------------------------------------------------------
`include "length_prefixed_message_deframer_defines.svh"

module length_prefixed_message_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // data_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // message_opcode, message_length, payload_byte
    output logic [1:0]  o_m_axis_tuser,   // has_payload, first_of_message
    output logic        o_m_axis_tlast    // last_of_message
);
    import lpmd_pkg::*;

    t_push  w_push;
    t_qstat w_qstat;
    t_entry w_head;
    logic   w_pop;

    lpmd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_data  (i_s_axis_tdata),
        .i_qstat (w_qstat),
        .o_ready (o_s_axis_tready),
        .o_push  (w_push)
    );

    lpmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_stat  (w_qstat),
        .o_head  (w_head)
    );

    lpmd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata),
        .o_user  (o_m_axis_tuser),
        .o_last  (o_m_axis_tlast)
    );

    // empty-message marker is always a single first-and-last result
    `LPMD_ASSERT_NOW(a_marker_framing, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser[0], o_m_axis_tuser[1] && o_m_axis_tlast)
    // marker carries zero length and zero data
    `LPMD_ASSERT_NOW(a_marker_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser[0], o_m_axis_tdata[47:8] == 40'd0)
    // the front never pushes into a full queue
    `LPMD_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, w_push.valid, w_qstat.can_push)
    // nothing is offered right after reset
    `LPMD_ASSERT_NEXT(a_reset_idle, i_clk, !i_rst_n, !o_m_axis_tvalid)

endmodule

// ===== tb/sv/length_prefixed_message_deframer_tb.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer_tb
// drives length/opcode/payload byte streams into the deframer with random
// gaps on both sides and checks every result against a local model
// ----------------------------------------------------------------------------
module length_prefixed_message_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpmd_pkg::*;

    localparam int N_BYTES      = 1900;
    localparam int CALM_FROM    = 1700;
    localparam int STUCK_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int N_SCRIPT     = 24;

    typedef enum logic [1:0] {
        ST_HEADER = 2'd0,
        ST_BODY   = 2'd1
    } t_stage;

    typedef struct packed {
        logic [BYTE_W-1:0] opcode;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] data;
        logic              has_payload;
        logic              first;
        logic              last;
    } t_frag;

    typedef struct packed {
        logic [BYTE_W-1:0] b;
        logic              pinned;
        t_frag             want;
    } t_row;

    // directed stream: empty message, one-byte message, short message,
    // empty message with all-ones opcode
    localparam t_row SCRIPT [N_SCRIPT] = '{
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'hA5, 1'b1, '{8'hA5, 32'd0, 8'h00, 1'b0, 1'b1, 1'b1}},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b1, '{8'hFF, 32'd1, 8'h00, 1'b1, 1'b1, 1'b1}},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h03, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h80, 1'b0, '0},
        '{8'h7F, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b1, '{8'hFF, 32'd0, 8'h00, 1'b0, 1'b1, 1'b1}}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [47:0] m_tdata;   // message_opcode, message_length, payload_byte
    logic [1:0]  m_tuser;   // has_payload, first_of_message
    logic        m_tlast;   // last_of_message

    length_prefixed_message_deframer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // local copy of the deframer state
    t_stage            stage;
    logic [2:0]        hdr_taken;
    logic [LEN_W-1:0]  len_acc;
    logic [BYTE_W-1:0] op_reg;
    logic [LEN_W-1:0]  bytes_left;
    logic              at_first;

    t_frag pending_frags[$];
    int    errors = 0;
    int    stuck_cycles = 0;
    int    n_sent = 0;
    bit    calm = 1'b0;
    bit    pin_on = 1'b0;
    t_frag pin_val = '0;
    int    ready_hold = 0;

    function automatic bit deframe_byte(input logic [7:0] b, output t_frag r);
        r = '0;
        if (stage == ST_BODY) begin
            r.opcode      = op_reg;
            r.length      = len_acc;
            r.data        = b;
            r.has_payload = 1'b1;
            r.first       = at_first;
            r.last        = (bytes_left <= 1);
            at_first = 1'b0;
            if (bytes_left != 0)
                bytes_left = bytes_left - 1;
            if (r.last) begin
                stage      = ST_HEADER;
                hdr_taken  = '0;
                bytes_left = '0;
                at_first   = 1'b1;
            end
            return 1'b1;
        end
        if (hdr_taken < HDR_LEN_BYTES) begin
            len_acc   = {len_acc[LEN_W-9:0], b};
            hdr_taken = hdr_taken + 1;
            return 1'b0;
        end
        // opcode byte
        op_reg    = b;
        hdr_taken = '0;
        at_first  = 1'b1;
        if (len_acc == 0) begin
            r.opcode = b;
            r.first  = 1'b1;
            r.last   = 1'b1;
            stage    = ST_HEADER;
            return 1'b1;
        end
        bytes_left = len_acc;
        stage      = ST_BODY;
        return 1'b0;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_frag r;
        t_frag want;
        bit    got_one;
        if (!i_rst_n) begin
            stage      = ST_HEADER;
            hdr_taken  = '0;
            len_acc    = '0;
            op_reg     = '0;
            bytes_left = '0;
            at_first   = 1'b1;
        end else begin
            if (s_tvalid && s_tready) begin
                got_one = deframe_byte(s_tdata, r);
                if (pin_on)
                    pending_frags.push_back(pin_val);
                else if (got_one)
                    pending_frags.push_back(r);
            end
            if (m_tvalid && m_tready) begin
                if (pending_frags.size() == 0) begin
                    $display("%0t unexpected result: expected none, actual %0h %0h %0b",
                             $time, m_tdata, m_tuser, m_tlast);
                    errors++;
                end else begin
                    want = pending_frags.pop_front();
                    check_field("message_opcode", want.opcode, m_tdata[7:0]);
                    check_field("message_length", want.length, m_tdata[39:8]);
                    check_field("payload_byte", want.data, m_tdata[47:40]);
                    check_field("has_payload", want.has_payload, m_tuser[0]);
                    check_field("first_of_message", want.first, m_tuser[1]);
                    check_field("last_of_message", want.last, m_tlast);
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
    end

    // output side back-pressure in bursts of random length
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (ready_hold != 0) begin
            m_tready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            ready_hold <= $urandom_range(0, 6);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // called at a falling edge, returns at a falling edge after the handshake
    task automatic send_byte(input logic [7:0] b, input bit pinned, input t_frag want);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        pin_on  = pinned;
        pin_val = want;
        do @(posedge i_clk); while (!s_tready);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_message(input logic [LEN_W-1:0] len, input int n_payload);
        send_byte(len[31:24], 1'b0, '0);
        send_byte(len[23:16], 1'b0, '0);
        send_byte(len[15:8], 1'b0, '0);
        send_byte(len[7:0], 1'b0, '0);
        send_byte(8'($urandom), 1'b0, '0);
        for (int i = 0; i < n_payload; i++)
            send_byte(8'($urandom), 1'b0, '0);
    endtask

    initial begin
        while (stuck_cycles < STUCK_LIMIT) @(posedge i_clk);
        $display("[length_prefixed_message_deframer] ERROR");
        $finish;
    end

    initial begin
        int len;
        int pick;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < N_SCRIPT; i++)
            send_byte(SCRIPT[i].b, SCRIPT[i].pinned, SCRIPT[i].want);

        // well-formed messages, mostly short
        while (n_sent < N_BYTES) begin
            if (n_sent >= CALM_FROM)
                calm = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 20)
                len = 0;
            else if (pick < 80)
                len = $urandom_range(1, 8);
            else if (pick < 96)
                len = $urandom_range(9, 40);
            else
                len = $urandom_range(100, 300);
            send_message(LEN_W'(len), len);
        end

        // largest length: only a slice of the payload is sent, never the last byte
        send_message('1, 20);
        s_tvalid <= 1'b0;

        while (pending_frags.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("[length_prefixed_message_deframer] OK");
        else
            $display("[length_prefixed_message_deframer] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lpmd_pkg.sv
rtl/lpmd_front.sv
rtl/lpmd_queue.sv
rtl/lpmd_back.sv
rtl/length_prefixed_message_deframer.sv
tb/sv/length_prefixed_message_deframer_tb.sv
